/* rtl/spmw_pkg.sv */
// Package: shared constants, payload structs, FSM states and control buses.
package spmw_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int MAX_EDGES_DEF = 1024;
  localparam int VAL_W         = 48;
  localparam int WGT_W         = 32;
  localparam int CNT_CFG_W     = 9;
  localparam logic [VAL_W-1:0]     SAT48          = {VAL_W{1'b1}};
  localparam logic [CNT_CFG_W-1:0] NODE_CNT_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_EDGE   = 2'd1,
    OP_RUN    = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [7:0]       node_a;
    logic [7:0]       node_b;
    logic [WGT_W-1:0] amount;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] best_value;
    logic [VAL_W-1:0] shortest_distance;
    logic             reachable;
    logic             edges_dropped;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_INIT_RD, S_INIT_WR, S_SCAN_START, S_SCAN, S_SCAN_END,
    S_SETTLE, S_EDGE_RD, S_EDGE_CHK, S_REL_RD, S_REL_CALC, S_REL_WR,
    S_EDGE_NEXT, S_FIN_RD, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic run_start;
    logic clr_wr;
    logic init_rd;
    logic init_wr;
    logic scan_start;
    logic scan_step;
    logic best_rd;
    logic settle;
    logic edge_rd;
    logic side_set;
    logic side_b;
    logic rel_rd;
    logic rel_calc;
    logic rel_wr;
    logic e_inc;
    logic fin_rd;
    logic fin_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic scan_done;
    logic found;
    logic edge_none;
    logic edge_last;
    logic rel_a;
    logic rel_b;
    logic side;
  } sts_t;

endpackage

/* rtl/spmw_ram.sv */
// Generic simple dual-port RAM with registered read.
module spmw_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] wa,
  input  logic [W-1:0]                       wd,
  input  logic                               re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] ra,
  output logic [W-1:0]                       rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

/* rtl/spmw_ctrl.sv */
// Controller: sequences loads, clear sweep, min scan, edge relaxation, result.
module spmw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  spmw_pkg::sts_t    sts,
  output spmw_pkg::cmd_t    cmd
);

  spmw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spmw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      spmw_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_op == spmw_pkg::OP_RUN) begin
          cmd.run_start = 1'b1;
          state_nxt     = spmw_pkg::S_CLR;
        end
      end
      spmw_pkg::S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.idx_last) begin
          state_nxt = spmw_pkg::S_INIT_RD;
        end
      end
      spmw_pkg::S_INIT_RD: begin
        cmd.init_rd = 1'b1;
        state_nxt   = spmw_pkg::S_INIT_WR;
      end
      spmw_pkg::S_INIT_WR: begin
        cmd.init_wr = 1'b1;
        state_nxt   = spmw_pkg::S_SCAN_START;
      end
      spmw_pkg::S_SCAN_START: begin
        cmd.scan_start = 1'b1;
        state_nxt      = spmw_pkg::S_SCAN;
      end
      spmw_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = spmw_pkg::S_SCAN_END;
        end
      end
      spmw_pkg::S_SCAN_END: begin
        if (sts.found) begin
          cmd.best_rd = 1'b1;
          state_nxt   = spmw_pkg::S_SETTLE;
        end else begin
          state_nxt = spmw_pkg::S_FIN_RD;
        end
      end
      spmw_pkg::S_SETTLE: begin
        cmd.settle = 1'b1;
        state_nxt  = sts.edge_none ? spmw_pkg::S_SCAN_START : spmw_pkg::S_EDGE_RD;
      end
      spmw_pkg::S_EDGE_RD: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = spmw_pkg::S_EDGE_CHK;
      end
      spmw_pkg::S_EDGE_CHK: begin
        if (sts.rel_a) begin
          cmd.side_set = 1'b1;
          state_nxt    = spmw_pkg::S_REL_RD;
        end else if (sts.rel_b) begin
          cmd.side_set = 1'b1;
          cmd.side_b   = 1'b1;
          state_nxt    = spmw_pkg::S_REL_RD;
        end else begin
          state_nxt = spmw_pkg::S_EDGE_NEXT;
        end
      end
      spmw_pkg::S_REL_RD: begin
        cmd.rel_rd = 1'b1;
        state_nxt  = spmw_pkg::S_REL_CALC;
      end
      spmw_pkg::S_REL_CALC: begin
        cmd.rel_calc = 1'b1;
        state_nxt    = spmw_pkg::S_REL_WR;
      end
      spmw_pkg::S_REL_WR: begin
        cmd.rel_wr = 1'b1;
        if (!sts.side && sts.rel_b) begin
          cmd.side_set = 1'b1;
          cmd.side_b   = 1'b1;
          state_nxt    = spmw_pkg::S_REL_RD;
        end else begin
          state_nxt = spmw_pkg::S_EDGE_NEXT;
        end
      end
      spmw_pkg::S_EDGE_NEXT: begin
        cmd.e_inc = 1'b1;
        state_nxt = sts.edge_last ? spmw_pkg::S_SCAN_START : spmw_pkg::S_EDGE_RD;
      end
      spmw_pkg::S_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_nxt  = spmw_pkg::S_FIN;
      end
      spmw_pkg::S_FIN: begin
        cmd.fin_load = 1'b1;
        state_nxt    = spmw_pkg::S_OUT;
      end
      spmw_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = spmw_pkg::S_IDLE;
        end
      end
      default: state_nxt = spmw_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/spmw_dp.sv */
// Datapath: graph stores, search stores, counters, relax arithmetic, result register.
module spmw_dp #(
  parameter int MAX_NODES = spmw_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = spmw_pkg::MAX_EDGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spmw_pkg::cmd_t                   cmd,
  input  spmw_pkg::in_t                    in_data,
  input  logic                             cfg_we,
  input  logic [spmw_pkg::CNT_CFG_W-1:0]   cfg_data,
  output spmw_pkg::sts_t                   sts,
  output spmw_pkg::out_t                   out_data
);

  localparam int NIW   = $clog2(MAX_NODES);
  localparam int NCW   = $clog2(MAX_NODES + 1);
  localparam int EIW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW   = $clog2(MAX_EDGES + 1);
  localparam int VW    = spmw_pkg::VAL_W;
  localparam int WW    = spmw_pkg::WGT_W;
  localparam int EDG_W = 16 + WW;

  logic [spmw_pkg::CNT_CFG_W-1:0] node_count_r;
  logic [ECW-1:0] edge_total_r;
  logic           ovf_r;
  logic [NCW-1:0] idx_r;
  logic           found_r;
  logic [NIW-1:0] best_idx_r, v_r;
  logic [VW-1:0]  best_dist_r, dist_v_r, val_v_r, d_r, vs_r;
  logic [EIW-1:0] e_r;
  logic           side_r;
  spmw_pkg::out_t out_r;

  logic [NCW-1:0] n;
  logic [NIW-1:0] last_idx, scan_idx, to_idx;
  logic [7:0]     ea, eb, to_node;
  logic [WW-1:0]  ecost;
  logic           in_range, cand, upd_dist, upd_val;
  logic [VW:0]    dsum, vsum;

  logic           w_we, w_re;
  logic [NIW-1:0] w_wa, w_ra;
  logic [WW-1:0]  w_rd;
  logic           e_we, e_re;
  logic [EDG_W-1:0] e_rd;
  logic           d_we, d_re;
  logic [NIW-1:0] d_wa, d_ra;
  logic [VW:0]    d_wd, d_rd;
  logic           v_we, v_re;
  logic [NIW-1:0] v_wa, v_ra;
  logic [VW-1:0]  v_wd, v_rd;

  always_comb begin
    if (node_count_r == '0) begin
      n = NCW'(1);
    end else if (32'(node_count_r) > 32'(MAX_NODES)) begin
      n = NCW'(MAX_NODES);
    end else begin
      n = NCW'(node_count_r);
    end
  end

  assign last_idx = NIW'(n - NCW'(1));
  assign scan_idx = NIW'(idx_r - NCW'(1));
  assign ea       = e_rd[EDG_W-1 -: 8];
  assign eb       = e_rd[EDG_W-9 -: 8];
  assign ecost    = e_rd[WW-1:0];
  assign in_range = (32'(ea) < 32'(n)) && (32'(eb) < 32'(n));
  assign to_node  = side_r ? ea : eb;
  assign to_idx   = NIW'(to_node);

  assign cand = !d_rd[VW] && (d_rd[VW-1:0] != spmw_pkg::SAT48) &&
                (!found_r || d_rd[VW-1:0] < best_dist_r);

  assign dsum = {1'b0, dist_v_r} + (VW+1)'(ecost);
  assign vsum = {1'b0, val_v_r} + (VW+1)'(w_rd);

  assign upd_dist = (d_r != spmw_pkg::SAT48) && (d_r < d_rd[VW-1:0]);
  assign upd_val  = (d_r != spmw_pkg::SAT48) &&
                    (upd_dist || (d_r == d_rd[VW-1:0] && vs_r > v_rd));

  // weight store
  assign w_we = cmd.accept && in_data.operation == spmw_pkg::OP_WEIGHT &&
                32'(in_data.node_a) < 32'(MAX_NODES);
  assign w_wa = NIW'(in_data.node_a);
  assign w_re = cmd.init_rd || cmd.rel_rd;
  assign w_ra = cmd.rel_rd ? to_idx : '0;

  // edge store
  assign e_we = cmd.accept && in_data.operation == spmw_pkg::OP_EDGE &&
                edge_total_r < ECW'(MAX_EDGES);
  assign e_re = cmd.edge_rd;

  // distance store, top bit is the settled flag
  always_comb begin
    d_we = 1'b0;
    d_wa = '0;
    d_wd = '0;
    if (cmd.clr_wr) begin
      d_we = 1'b1;
      d_wa = NIW'(idx_r);
      d_wd = {1'b0, spmw_pkg::SAT48};
    end else if (cmd.init_wr) begin
      d_we = 1'b1;
    end else if (cmd.settle) begin
      d_we = 1'b1;
      d_wa = best_idx_r;
      d_wd = {1'b1, best_dist_r};
    end else if (cmd.rel_wr && upd_dist) begin
      d_we = 1'b1;
      d_wa = to_idx;
      d_wd = {d_rd[VW], d_r};
    end
    d_re = (cmd.scan_step && idx_r < n) || cmd.rel_rd || cmd.fin_rd;
    if (cmd.rel_rd) begin
      d_ra = to_idx;
    end else if (cmd.fin_rd) begin
      d_ra = last_idx;
    end else begin
      d_ra = NIW'(idx_r);
    end
  end

  // path value store
  always_comb begin
    v_we = 1'b0;
    v_wa = '0;
    v_wd = '0;
    if (cmd.clr_wr) begin
      v_we = 1'b1;
      v_wa = NIW'(idx_r);
    end else if (cmd.init_wr) begin
      v_we = 1'b1;
      v_wd = VW'(w_rd);
    end else if (cmd.rel_wr && upd_val) begin
      v_we = 1'b1;
      v_wa = to_idx;
      v_wd = vs_r;
    end
    v_re = cmd.best_rd || cmd.rel_rd || cmd.fin_rd;
    if (cmd.rel_rd) begin
      v_ra = to_idx;
    end else if (cmd.fin_rd) begin
      v_ra = last_idx;
    end else begin
      v_ra = best_idx_r;
    end
  end

  spmw_ram #(.W(WW), .D(MAX_NODES)) u_wgt (
    .clk(clk), .we(w_we), .wa(w_wa), .wd(in_data.amount),
    .re(w_re), .ra(w_ra), .rd(w_rd)
  );

  spmw_ram #(.W(EDG_W), .D(MAX_EDGES)) u_edge (
    .clk(clk), .we(e_we), .wa(EIW'(edge_total_r)),
    .wd({in_data.node_a, in_data.node_b, in_data.amount}),
    .re(e_re), .ra(e_r), .rd(e_rd)
  );

  spmw_ram #(.W(VW + 1), .D(MAX_NODES)) u_dist (
    .clk(clk), .we(d_we), .wa(d_wa), .wd(d_wd),
    .re(d_re), .ra(d_ra), .rd(d_rd)
  );

  spmw_ram #(.W(VW), .D(MAX_NODES)) u_val (
    .clk(clk), .we(v_we), .wa(v_wa), .wd(v_wd),
    .re(v_re), .ra(v_ra), .rd(v_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= spmw_pkg::NODE_CNT_RESET;
      edge_total_r <= '0;
      ovf_r        <= 1'b0;
      idx_r        <= '0;
      found_r      <= 1'b0;
      e_r          <= '0;
      side_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_data;
      end
      if (cmd.accept && in_data.operation == spmw_pkg::OP_EDGE) begin
        if (e_we) begin
          edge_total_r <= edge_total_r + ECW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.run_start || cmd.scan_start) begin
        idx_r <= '0;
      end else if (cmd.clr_wr || cmd.scan_step) begin
        idx_r <= idx_r + NCW'(1);
      end
      if (cmd.scan_start) begin
        found_r <= 1'b0;
      end else if (cmd.scan_step && idx_r != '0 && cand) begin
        found_r <= 1'b1;
      end
      if (cmd.settle) begin
        e_r <= '0;
      end else if (cmd.e_inc) begin
        e_r <= e_r + EIW'(1);
      end
      if (cmd.side_set) begin
        side_r <= cmd.side_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && idx_r != '0 && cand) begin
      best_idx_r  <= scan_idx;
      best_dist_r <= d_rd[VW-1:0];
    end
    if (cmd.init_wr) begin
      dist_v_r <= '0;
    end
    if (cmd.settle) begin
      v_r      <= best_idx_r;
      dist_v_r <= best_dist_r;
      val_v_r  <= v_rd;
    end else if (cmd.rel_wr && upd_val && to_idx == v_r) begin
      val_v_r <= vs_r;
    end
    if (cmd.rel_calc) begin
      d_r  <= dsum[VW] ? spmw_pkg::SAT48 : dsum[VW-1:0];
      vs_r <= vsum[VW] ? spmw_pkg::SAT48 : vsum[VW-1:0];
    end
    if (cmd.fin_load) begin
      if (d_rd[VW-1:0] != spmw_pkg::SAT48) begin
        out_r.best_value        <= v_rd;
        out_r.shortest_distance <= d_rd[VW-1:0];
        out_r.reachable         <= 1'b1;
      end else begin
        out_r.best_value        <= '0;
        out_r.shortest_distance <= spmw_pkg::SAT48;
        out_r.reachable         <= 1'b0;
      end
      out_r.edges_dropped <= ovf_r;
    end
  end

  assign sts.idx_last  = (idx_r == n - NCW'(1));
  assign sts.scan_done = (idx_r == n);
  assign sts.found     = found_r;
  assign sts.edge_none = (edge_total_r == '0);
  assign sts.edge_last = (ECW'(e_r) + ECW'(1) == edge_total_r);
  assign sts.rel_a     = in_range && (32'(ea) == 32'(v_r));
  assign sts.rel_b     = in_range && (32'(eb) == 32'(v_r));
  assign sts.side      = side_r;
  assign out_data      = out_r;

endmodule

/* rtl/shortest_path_max_weight_tiebreak.sv */
// Top level: shortest path from node 0 with heaviest-path tiebreak.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | spmw_pkg::in_t
//   out_    | output    | out_valid/out_stall | spmw_pkg::out_t
//   cfg_    | input     | cfg_valid/cfg_ready | node_count, 9 bits
//
// Weight and edge load transactions are taken one per cycle while no search is under way.
// A search transaction offers its result after accept once no reachable node is
// left unsettled: each min scan over the n nodes that finds a node settles it,
// and its pass then reads every stored edge and relaxes each end that touches it.
// The search opens with a clear sweep over the nodes; reset is synchronous.
// in_stall is high from search accept until the result is taken.
module shortest_path_max_weight_tiebreak #(
  parameter int MAX_NODES = spmw_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = spmw_pkg::MAX_EDGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  spmw_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output spmw_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spmw_pkg::CNT_CFG_W-1:0] cfg_data
);

  spmw_pkg::cmd_t cmd;
  spmw_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  spmw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_op(in_data.operation), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  spmw_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .sts(sts), .out_data(out_data)
  );

endmodule

/* tb/testbench.sv */
// Testbench for shortest_path_max_weight_tiebreak against an in-bench Dijkstra predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spmw_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CNT_CFG_W-1:0] cfg_data;

  shortest_path_max_weight_tiebreak DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  in_t item_queue[$];
  out_t expected_paths[$];
  int mismatches = 0;
  int edges_sent = 0;
  int items_sent = 0;
  bit calm = 0;
  bit in_fire = 0;
  int gap_left = 0;
  int stall_left = 0;

  // graph mirror
  logic [WGT_W-1:0] node_wgt[MAX_NODES_DEF];
  logic [7:0] edge_a[MAX_EDGES_DEF];
  logic [7:0] edge_b[MAX_EDGES_DEF];
  logic [WGT_W-1:0] edge_cost[MAX_EDGES_DEF];
  int edge_count = 0;
  bit dropped = 0;
  logic [CNT_CFG_W-1:0] node_cnt = NODE_CNT_RESET;
  logic [VAL_W-1:0] node_dist[MAX_NODES_DEF];
  logic [VAL_W-1:0] path_val[MAX_NODES_DEF];
  bit done[MAX_NODES_DEF];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y);
    logic [63:0] s;
    s = 64'(x) + 64'(y);
    return (s > 64'(SAT48)) ? SAT48 : s[VAL_W-1:0];
  endfunction

  function automatic void relax(int from, int to, logic [WGT_W-1:0] cost);
    logic [VAL_W-1:0] d;
    logic [VAL_W-1:0] v;
    d = sat_add(node_dist[from], VAL_W'(cost));
    v = sat_add(path_val[from], VAL_W'(node_wgt[to]));
    if (d == SAT48) return;
    if (d < node_dist[to]) begin
      node_dist[to] = d;
      path_val[to] = v;
    end else if (d == node_dist[to] && v > path_val[to]) begin
      path_val[to] = v;
    end
  endfunction

  function automatic out_t predict_search();
    int n;
    int best;
    bit found;
    out_t r;
    n = node_cnt;
    if (n < 1) n = 1;
    if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
    for (int i = 0; i < n; i++) begin
      node_dist[i] = SAT48;
      path_val[i] = '0;
      done[i] = 0;
    end
    node_dist[0] = '0;
    path_val[0] = VAL_W'(node_wgt[0]);
    while (1) begin
      found = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        if (!done[i] && node_dist[i] != SAT48 &&
            (!found || node_dist[i] < node_dist[best])) begin
          best = i;
          found = 1;
        end
      end
      if (!found) break;
      done[best] = 1;
      for (int e = 0; e < edge_count; e++) begin
        if (edge_a[e] >= n || edge_b[e] >= n) continue;
        if (edge_a[e] == best) relax(best, edge_b[e], edge_cost[e]);
        if (edge_b[e] == best) relax(best, edge_a[e], edge_cost[e]);
      end
    end
    if (node_dist[n-1] != SAT48) begin
      r.best_value = path_val[n-1];
      r.shortest_distance = node_dist[n-1];
      r.reachable = 1'b1;
    end else begin
      r.best_value = '0;
      r.shortest_distance = SAT48;
      r.reachable = 1'b0;
    end
    r.edges_dropped = dropped;
    return r;
  endfunction

  // predictor and result check
  always @(posedge clk) begin
    out_t exp_r;
    in_fire <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) node_cnt = cfg_data;
      if (in_valid && !in_stall) begin
        case (in_data.operation)
          OP_WEIGHT: node_wgt[in_data.node_a] = in_data.amount;
          OP_EDGE: begin
            if (edge_count < MAX_EDGES_DEF) begin
              edge_a[edge_count] = in_data.node_a;
              edge_b[edge_count] = in_data.node_b;
              edge_cost[edge_count] = in_data.amount;
              edge_count++;
            end else begin
              dropped = 1;
            end
          end
          OP_RUN: expected_paths.push_back(predict_search());
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_paths.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", out_data);
        end else begin
          exp_r = expected_paths.pop_front();
          if (out_data.best_value !== exp_r.best_value ||
              out_data.shortest_distance !== exp_r.shortest_distance ||
              out_data.reachable !== exp_r.reachable ||
              out_data.edges_dropped !== exp_r.edges_dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected value=%0d dist=%0d reach=%0b drop=%0b,",
                        " got value=%0d dist=%0d reach=%0b drop=%0b"},
                       exp_r.best_value, exp_r.shortest_distance, exp_r.reachable,
                       exp_r.edges_dropped, out_data.best_value,
                       out_data.shortest_distance, out_data.reachable,
                       out_data.edges_dropped);
          end
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_queue.size() > 0) begin
        in_data <= item_queue.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
    end
  end

  task automatic push(op_t op, int a, int b, logic [WGT_W-1:0] amt);
    in_t it;
    it.operation = op;
    it.node_a = 8'(a);
    it.node_b = 8'(b);
    it.amount = amt;
    item_queue.push_back(it);
    items_sent++;
    if (op == OP_EDGE) edges_sent++;
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (item_queue.size() != 0 || in_valid || expected_paths.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_count(logic [CNT_CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [WGT_W-1:0] rand_amt();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8);
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  initial begin
    int n;
    int lim;
    in_t odd;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // every weight defined before any search
    for (int i = 0; i < MAX_NODES_DEF; i++)
      push(OP_WEIGHT, i, 0, (i % 3 == 0) ? '1 : (i % 3 == 1) ? 32'(0) : 32'($urandom));
    push(OP_RUN, 0, 0, 0);                   // no edges, count from reset
    push(OP_EDGE, 0, 255, '1);
    push(OP_RUN, 255, 255, '1);
    odd = '0;
    odd.operation = OP_NOP;
    odd.node_a = 8'hFF;
    item_queue.push_back(odd);
    wait_idle();
    write_count(9'd1);
    push(OP_RUN, 0, 0, 0);
    wait_idle();
    write_count(9'd0);
    push(OP_RUN, 0, 0, 0);
    wait_idle();
    write_count(9'd511);
    push(OP_RUN, 0, 0, 0);
    wait_idle();
    write_count(9'd4);
    push(OP_EDGE, 0, 1, 5);
    push(OP_EDGE, 1, 3, 5);
    push(OP_EDGE, 0, 2, 3);
    push(OP_EDGE, 2, 3, 7);                  // tie at distance 10
    push(OP_EDGE, 3, 3, 2);                  // self loop
    push(OP_EDGE, 1, 0, 0);                  // zero cost back to settled node
    push(OP_EDGE, 2, 9, 1);                  // end outside node count
    push(OP_WEIGHT, 3, 0, 32'd100);
    push(OP_RUN, 0, 0, 0);
    wait_idle();

    while (items_sent < 640) begin
      case ($urandom_range(0, 9))
        0: n = 1;
        1: n = (($urandom_range(0, 1) == 1) ? 256 : $urandom_range(257, 511));
        default: n = $urandom_range(2, 12);
      endcase
      write_count(CNT_CFG_W'(n));
      if (n > 16) n = 12;
      lim = $urandom_range(5, 25);
      for (int k = 0; k < lim; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6:
            push(OP_WEIGHT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                 : $urandom_range(0, n + 1), 0, rand_amt());
          7, 8, 9, 10, 11, 12:
            if (edges_sent < 330)
              push(OP_EDGE, ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, n + 1),
                   $urandom_range(0, n + 1), rand_amt());
          13: begin
            odd.operation = OP_NOP;
            odd.node_a = 8'($urandom);
            odd.node_b = 8'($urandom);
            odd.amount = $urandom;
            item_queue.push_back(odd);
          end
          14, 15: push(OP_RUN, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
          default: push(OP_WEIGHT, n - 1, 0, rand_amt());
        endcase
      end
      push(OP_RUN, 0, 0, 0);
      wait_idle();
    end

    // edge store overflow, no random input gaps or result stalls from here on
    calm = 1;
    write_count(9'd2);
    push(OP_EDGE, 0, 1, 9);
    while (edges_sent < MAX_EDGES_DEF + 4) push(OP_EDGE, 255, 254, $urandom);
    push(OP_RUN, 0, 0, 0);
    wait_idle();
    write_count(9'd1);
    push(OP_RUN, 0, 0, 0);
    wait_idle();
    write_count(9'd256);
    push(OP_RUN, 0, 0, 0);
    wait_idle();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && expected_paths.size() == 0) begin
      $display("shortest_path_max_weight_tiebreak test passed");
    end else begin
      $display("shortest_path_max_weight_tiebreak test failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("shortest_path_max_weight_tiebreak test failed");
    $finish;
  end

endmodule
